// ===== rtl/swrl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the sliding window rate limiter.
// No dependencies.
package swrl_pkg;
  localparam int TableEntriesDef = 64;
  localparam int LogDepthDef     = 64;
  localparam int TimeBitsDef     = 48;
  localparam int CfgIdxBits      = 1;
  localparam int CfgDataBits     = 32;

  localparam logic [CfgIdxBits-1:0] REG_WINDOW_MS  = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_MAX_EVENTS = 1'd1;

  localparam logic [1:0] FUNC_CHECK  = 2'd0;
  localparam logic [1:0] FUNC_RECORD = 2'd1;
  localparam logic [1:0] FUNC_SWEEP  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_RING_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] client_id;
    logic [47:0] now_ms;
    logic [47:0] max_age_ms;
  } req_t;

  typedef struct packed {
    logic       allowed;
    logic [6:0] window_count;
    logic [1:0] status;
    logic [6:0] tracked_clients;
  } rsp_t;
endpackage

// ===== rtl/swrl_ring_mem.sv =====
`timescale 1ns / 1ps
// Stamp ring storage: one synchronous memory, one write and one read port.
// Depends on nothing.
module swrl_ring_mem #(
  parameter int AddrBits = 12,
  parameter int DataBits = 48
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [DataBits-1:0] wdata,
  input  logic [AddrBits-1:0] raddr,
  output logic [DataBits-1:0] rdata
);
  logic [DataBits-1:0] mem [2**AddrBits];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/sliding_window_rate_limiter.sv =====
`timescale 1ns / 1ps
// Sliding window rate limiter top level. Uses swrl_pkg and swrl_ring_mem.
//
// One request at a time. A check or record first scans the client table,
// reading the metadata of each entry in turn (S_SCAN, S_SCAN_WAIT), then
// pops expired stamps from the ring memory, one stamp read at a time, then
// appends on record. Sweep and clear also scan the table entry by entry.
// Entry metadata (key, last seen, head, fill) lives in a second memory read
// one entry per access. The result waits in an output register; the next
// request is taken once it has been handed over. Memories need no clearing:
// only the contents of valid entries are ever used, and an entry is written
// when created.
module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDef,
  parameter int LOG_DEPTH     = LogDepthDef,
  parameter int TIME_BITS     = TimeBitsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  req_t                   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rsp_t                   out_data
);
  localparam int EB = $clog2(TABLE_ENTRIES);
  localparam int DB = $clog2(LOG_DEPTH);
  localparam int FB = $clog2(LOG_DEPTH + 1);
  localparam int CB = $clog2(TABLE_ENTRIES + 1);
  localparam int KB = (FB > 7) ? FB : 7;
  localparam logic [DB-1:0] LastPos = DB'(LOG_DEPTH - 1);
  localparam logic [FB-1:0] FullFill = FB'(LOG_DEPTH);

  typedef struct packed {
    logic [63:0]          key;
    logic [TIME_BITS-1:0] last_seen;
    logic [DB-1:0]        head;
    logic [FB-1:0]        fill;
  } meta_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_META, S_RD, S_CMP, S_FIN, S_WALK, S_DONE
  } state_t;

  state_t state;
  logic [31:0] window_ms;
  logic [6:0]  max_events;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CB-1:0] tracked;

  // request copy
  logic [1:0]           func;
  logic [63:0]          key;
  logic [TIME_BITS-1:0] now, cutoff;

  logic [EB-1:0] idx;       // scan counter
  logic [EB-1:0] hit_idx, free_idx;
  logic          hit, free_found;
  logic [EB-1:0] ent;
  meta_t         cur;

  // metadata memory
  meta_t meta_mem [TABLE_ENTRIES];
  meta_t meta_rd;
  logic  meta_we;
  logic [EB-1:0] meta_raddr;
  meta_t meta_wd;

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[ent] <= meta_wd;
    meta_rd <= meta_mem[meta_raddr];
  end

  // ring memory
  logic                 ring_we;
  logic [EB+DB-1:0]     ring_waddr, ring_raddr;
  logic [TIME_BITS-1:0] ring_rd;

  swrl_ring_mem #(.AddrBits(EB + DB), .DataBits(TIME_BITS)) u_ring (
    .clk, .we(ring_we), .waddr(ring_waddr), .wdata(now),
    .raddr(ring_raddr), .rdata(ring_rd)
  );

  logic [DB-1:0] tail;
  logic [DB:0]   tail_sum;
  assign tail_sum   = {1'b0, cur.head} + (DB+1)'(cur.fill);
  assign tail       = (tail_sum >= (DB+1)'(LOG_DEPTH)) ? DB'(tail_sum - (DB+1)'(LOG_DEPTH))
                                                       : tail_sum[DB-1:0];
  assign ring_raddr = {ent, cur.head};
  assign ring_waddr = {ent, tail};
  // during the walk the hit entry is fetched so that it is ready in S_META
  assign meta_raddr = (state == S_SCAN) ? idx :
                      (state == S_WALK) ? hit_idx : ent;

  logic [TIME_BITS-1:0] now_in, age_in, win_ext;
  assign now_in  = TIME_BITS'(in_data.now_ms);
  assign age_in  = TIME_BITS'(in_data.max_age_ms);
  assign win_ext = TIME_BITS'(window_ms);

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign ring_we  = (state == S_FIN) && (func == FUNC_RECORD) && (cur.fill != FullFill);
  assign meta_we  = (state == S_FIN);
  always_comb begin
    meta_wd = cur;
    if (ring_we) begin
      meta_wd.fill      = cur.fill + FB'(1);
      meta_wd.last_seen = now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window_ms  <= 32'd1000;
      max_events <= 7'd20;
      valid      <= '0;
      tracked    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW_MS:  window_ms  <= cfg_data;
          REG_MAX_EVENTS: max_events <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            func <= in_data.func;
            key  <= in_data.client_id;
            now  <= now_in;
            // saturating cutoff
            if (in_data.func == FUNC_SWEEP) cutoff <= (now_in > age_in) ? now_in - age_in : '0;
            else cutoff <= (now_in > win_ext) ? now_in - win_ext : '0;
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            out_data   <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read issued for idx; data arrives next cycle
          ent   <= idx;
          state <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: begin
          unique case (func)
            FUNC_CLEAR: valid[ent] <= 1'b0;
            FUNC_SWEEP: if (valid[ent] && meta_rd.last_seen < cutoff) valid[ent] <= 1'b0;
            default: begin
              if (valid[ent] && meta_rd.key == key && !hit) begin
                hit <= 1'b1; hit_idx <= ent;
              end
              if (!valid[ent] && !free_found) begin
                free_found <= 1'b1; free_idx <= ent;
              end
            end
          endcase
          if (idx == EB'(TABLE_ENTRIES - 1)) state <= S_WALK;
          else begin
            idx   <= idx + EB'(1);
            state <= S_SCAN;
          end
        end
        S_WALK: begin
          state <= S_DONE;
          if (func == FUNC_CHECK) begin
            if (!hit) out_data.allowed <= 1'b1;
            else begin ent <= hit_idx; state <= S_META; end
          end else if (func == FUNC_RECORD) begin
            if (hit) begin ent <= hit_idx; state <= S_META; end
            else if (free_found) begin
              ent          <= free_idx;
              valid[free_idx] <= 1'b1;
              tracked      <= tracked + CB'(1);
              cur.key      <= key;
              cur.last_seen <= now;
              cur.head     <= '0;
              cur.fill     <= '0;
              state        <= S_RD;
            end else out_data.status <= ST_TABLE_FULL;
          end else begin
            tracked <= CB'($countones(valid));
          end
        end
        S_META: begin
          state <= S_RD;   // meta_rd holds the hit entry in this cycle
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (cur.fill != '0 && ring_rd < cutoff) begin
            cur.head <= (cur.head == LastPos) ? '0 : cur.head + DB'(1);
            cur.fill <= cur.fill - FB'(1);
            state    <= S_RD;
          end else state <= S_FIN;
        end
        S_FIN: begin
          if (func == FUNC_RECORD) begin
            if (cur.fill == FullFill) begin
              out_data.status       <= ST_RING_FULL;
              out_data.window_count <= 7'(cur.fill);
            end else out_data.window_count <= 7'(cur.fill + FB'(1));
          end else begin
            out_data.window_count <= 7'(cur.fill);
            out_data.allowed      <= (KB'(cur.fill) < KB'(max_events));
          end
          state <= S_DONE;
        end
        S_DONE: begin
          out_data.tracked_clients <= 7'(tracked);
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_META) cur <= meta_rd;
    end
  end
endmodule

// ===== sim/tb_sliding_window_rate_limiter.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sliding_window_rate_limiter: random and directed requests
// checked against an in-bench predictor of the client table. Uses swrl_pkg.
module tb_sliding_window_rate_limiter;
  import swrl_pkg::*;

  localparam int NENT  = 64;
  localparam int DEPTH = 64;
  localparam int QLEN  = 4096;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  sliding_window_rate_limiter i_dut (.*);

  initial forever #6 clk = ~clk;

  // predictor state
  logic [31:0] win_ms;
  logic [6:0]  limit;
  bit          tbl_valid [NENT];
  logic [63:0] tbl_key   [NENT];
  logic [47:0] tbl_seen  [NENT];
  logic [47:0] stamps    [NENT][DEPTH];
  int          head      [NENT];
  int          fill      [NENT];

  // pending requests and expected responses, kept as ring lists
  req_t pend_q [QLEN];
  int   pend_wr = 0, pend_rd = 0;
  rsp_t exp_q  [QLEN];
  int   exp_wr = 0, exp_rd = 0;
  int errors = 0, n_req = 0, n_rsp = 0, n_allow = 0, n_tfull = 0, n_rfull = 0;
  int idle_cnt = 0;
  logic [47:0] clock_ms = '0;
  logic [63:0] id_pool [8];

  task automatic report(input string what);
    errors++;
    $display("ERROR t=%0t: %s", $realtime, what);
  endtask

  task automatic add_req(input req_t r);
    pend_q[pend_wr % QLEN] = r;
    pend_wr++;
  endtask

  function automatic logic [47:0] cutoff_of(logic [47:0] t, logic [47:0] span);
    return (t > span) ? t - span : 48'd0;
  endfunction

  function automatic int lookup(logic [63:0] k);
    for (int i = 0; i < NENT; i++) if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void drop_old(int e, logic [47:0] cut);
    while (fill[e] > 0 && stamps[e][head[e]] < cut) begin
      head[e] = (head[e] + 1) % DEPTH;
      fill[e]--;
    end
  endfunction

  // Apply one request to the table model and return the response it should give.
  function automatic rsp_t predict_limiter(req_t r);
    rsp_t o;
    int e, pos, cnt;
    logic [47:0] cut;
    o = '0;
    cut = cutoff_of(r.now_ms, {16'd0, win_ms});
    case (r.func)
      FUNC_CHECK: begin
        e = lookup(r.client_id);
        if (e < 0) o.allowed = 1'b1;
        else begin
          drop_old(e, cut);
          o.window_count = fill[e][6:0];
          o.allowed = (fill[e] < limit);
        end
      end
      FUNC_RECORD: begin
        e = lookup(r.client_id);
        if (e < 0) begin
          for (int i = 0; i < NENT; i++) if (!tbl_valid[i]) begin
            e = i;
            break;
          end
          if (e >= 0) begin
            tbl_valid[e] = 1; tbl_key[e] = r.client_id; head[e] = 0; fill[e] = 0;
          end
        end
        if (e < 0) o.status = ST_TABLE_FULL;
        else begin
          drop_old(e, cut);
          if (fill[e] >= DEPTH) o.status = ST_RING_FULL;
          else begin
            pos = (head[e] + fill[e]) % DEPTH;
            stamps[e][pos] = r.now_ms;
            fill[e]++;
            tbl_seen[e] = r.now_ms;
          end
          o.window_count = fill[e][6:0];
        end
      end
      FUNC_SWEEP: begin
        cut = cutoff_of(r.now_ms, r.max_age_ms);
        for (int i = 0; i < NENT; i++)
          if (tbl_valid[i] && tbl_seen[i] < cut) tbl_valid[i] = 0;
      end
      default: for (int i = 0; i < NENT; i++) tbl_valid[i] = 0;
    endcase
    cnt = 0;
    for (int i = 0; i < NENT; i++) if (tbl_valid[i]) cnt++;
    o.tracked_clients = cnt[6:0];
    return o;
  endfunction

  function automatic req_t mk(logic [1:0] f, logic [63:0] id, logic [47:0] t,
                              logic [47:0] age);
    req_t r;
    r.func = f; r.client_id = id; r.now_ms = t; r.max_age_ms = age;
    return r;
  endfunction

  // Driver: one request at a time from the list, random gap before each.
  int gap_in = 0;
  bit in_accepted;
  always @(posedge clk) in_accepted <= !rst && in_valid && in_ready;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // hold
    end else if (gap_in > 0) begin
      gap_in <= gap_in - 1;
      in_valid <= 1'b0;
    end else if (pend_wr != pend_rd) begin
      in_data <= pend_q[pend_rd % QLEN];
      pend_rd++;
      in_valid <= 1'b1;
      gap_in <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Predict on acceptance at the rising edge.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      exp_q[exp_wr % QLEN] = predict_limiter(in_data);
      exp_wr++;
      n_req++;
    end
  end

  // Monitor and receiver stalls.
  int stall = 0;
  always @(posedge clk) begin
    rsp_t x;
    if (!rst && out_valid && out_ready) begin
      n_rsp++;
      if (exp_wr == exp_rd) report("response with nothing expected");
      else begin
        x = exp_q[exp_rd % QLEN];
        exp_rd++;
        if (out_data.allowed !== x.allowed)
          report($sformatf("allowed %0d exp %0d", out_data.allowed, x.allowed));
        if (out_data.window_count !== x.window_count)
          report($sformatf("window_count %0d exp %0d", out_data.window_count,
                           x.window_count));
        if (out_data.status !== x.status)
          report($sformatf("status %0d exp %0d", out_data.status, x.status));
        if (out_data.tracked_clients !== x.tracked_clients)
          report($sformatf("tracked_clients %0d exp %0d", out_data.tracked_clients,
                           x.tracked_clients));
        if (x.allowed) n_allow++;
        if (x.status == ST_TABLE_FULL) n_tfull++;
        if (x.status == ST_RING_FULL) n_rfull++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (out_valid && out_ready) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      out_ready <= (stall == 0);
    end else if (stall > 0) begin
      stall--;
      out_ready <= (stall == 0);
    end else out_ready <= 1'b1;
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("sliding_window_rate_limiter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_MS) win_ms = val;
    else limit = val[6:0];
  endtask

  task automatic drain();
    while (pend_wr != pend_rd || in_valid || exp_wr != exp_rd)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rnd48();
    return {16'($urandom_range(0, 65535)), $urandom};
  endfunction

  // Time moves forward a little; occasionally it steps backward.
  function automatic logic [47:0] tick(int step);
    if ($urandom_range(0, 40) == 0 && clock_ms > 50) clock_ms = clock_ms - 48'd30;
    else clock_ms = clock_ms + 48'(step);
    return clock_ms;
  endfunction

  // Random phase: mostly records and checks on a small client pool.
  task automatic random_phase(int n, int step, int pool);
    int u;
    logic [63:0] id;
    for (int k = 0; k < n; k++) begin
      u = $urandom_range(0, 99);
      id = id_pool[$urandom_range(0, pool - 1)];
      if ($urandom_range(0, 15) == 0) id = rnd64();
      if (u < 45) add_req(mk(FUNC_RECORD, id, tick(step), rnd48()));
      else if (u < 88) add_req(mk(FUNC_CHECK, id, tick(step), rnd48()));
      else if (u < 97)
        add_req(mk(FUNC_SWEEP, id, tick(step), 48'($urandom_range(0, 20 * step))));
      else if (u < 98) add_req(mk(FUNC_SWEEP, rnd64(), rnd48(), rnd48()));
      else add_req(mk(FUNC_CLEAR, rnd64(), tick(step), rnd48()));
    end
    drain();
  endtask

  initial begin
    win_ms = 32'd1000;
    limit = 7'd20;
    for (int i = 0; i < NENT; i++) begin
      tbl_valid[i] = 0; head[i] = 0; fill[i] = 0;
    end
    for (int i = 0; i < 8; i++) id_pool[i] = rnd64();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: early time, unknown client, extremes of the fields, all funcs.
    add_req(mk(FUNC_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, 48'd0));
    add_req(mk(FUNC_RECORD, 64'd0, 48'd0, 48'hFFFF_FFFF_FFFF));
    add_req(mk(FUNC_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 48'd5, 48'd0));
    add_req(mk(FUNC_CHECK, 64'd0, 48'd500, 48'd0));
    add_req(mk(FUNC_RECORD, 64'd0, 48'd1500, 48'd0));
    add_req(mk(FUNC_CHECK, 64'd0, 48'd1200, 48'd0));
    add_req(mk(FUNC_SWEEP, 64'd0, 48'd100, 48'd1000));
    add_req(mk(FUNC_SWEEP, 64'd0, 48'd1400, 48'd1000));
    add_req(mk(FUNC_CLEAR, 64'hA5A5_5A5A_0F0F_F0F0, 48'd1500, 48'd0));
    add_req(mk(FUNC_CHECK, 64'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    add_req(mk(FUNC_SWEEP, 64'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    drain();

    // Table full: 64 distinct clients fill the table, then two more.
    for (int i = 0; i < 66; i++)
      add_req(mk(FUNC_RECORD, 64'h1000 + 64'(i), 48'd2000, 48'd0));
    add_req(mk(FUNC_CLEAR, 64'd0, 48'd2000, 48'd0));
    drain();

    // Ring full with a limit equal to the ring depth; then max limit checks.
    write_reg(REG_MAX_EVENTS, 32'd64);
    write_reg(REG_WINDOW_MS, 32'hFFFF_FFFF);
    for (int i = 0; i < 67; i++)
      add_req(mk(FUNC_RECORD, 64'h77, 48'd3000 + 48'(i), 48'd0));
    add_req(mk(FUNC_CHECK, 64'h77, 48'd3100, 48'd0));
    drain();
    write_reg(REG_MAX_EVENTS, 32'h7F);
    add_req(mk(FUNC_CHECK, 64'h77, 48'd3100, 48'd0));
    add_req(mk(FUNC_CLEAR, 64'd0, 48'd3100, 48'd0));
    drain();
    clock_ms = 48'd4000;

    // Random phases over several settings.
    write_reg(REG_WINDOW_MS, 32'd1); write_reg(REG_MAX_EVENTS, 32'd1);
    random_phase(200, 1, 8);
    write_reg(REG_WINDOW_MS, 32'd100); write_reg(REG_MAX_EVENTS, 32'd0);
    random_phase(150, 7, 6);
    write_reg(REG_WINDOW_MS, 32'd1000); write_reg(REG_MAX_EVENTS, 32'd20);
    random_phase(225, 20, 4);
    write_reg(REG_WINDOW_MS, 32'd5000); write_reg(REG_MAX_EVENTS, 32'd64);
    random_phase(225, 3, 2);
    write_reg(REG_WINDOW_MS, 32'hFFFF_FFFF); write_reg(REG_MAX_EVENTS, 32'd5);
    random_phase(200, 40, 8);
    write_reg(REG_WINDOW_MS, 32'd30); write_reg(REG_MAX_EVENTS, 32'd3);
    random_phase(200, 10, 8);

    $display("ran %0d requests, %0d responses: %0d allowed, %0d table-full, %0d ring-full",
             n_req, n_rsp, n_allow, n_tfull, n_rfull);
    if (errors == 0 && exp_wr == exp_rd)
      $display("sliding_window_rate_limiter regression: pass");
    else
      $display("sliding_window_rate_limiter regression: fail");
    $finish;
  end
endmodule

// ===== sliding_window_rate_limiter.f =====
rtl/swrl_pkg.sv
rtl/swrl_ring_mem.sv
rtl/sliding_window_rate_limiter.sv
sim/tb_sliding_window_rate_limiter.sv
